FILE: rtl/rlei_pkg.sv
// Package for the run-length image unit decoder.
// Holds decode phase type, pixel format codes, register indexes and unit conversion.
// No dependencies.
package rlei_pkg;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_REPEAT  = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	localparam logic [1:0] FMT_MONO8   = 2'd0;
	localparam logic [1:0] FMT_MONO16  = 2'd1;
	localparam logic [1:0] FMT_RGB332  = 2'd2;
	localparam logic [1:0] FMT_RGB565  = 2'd3;

	localparam logic REG_PIXEL_FORMAT = 1'b0;
	localparam logic REG_RLE_ENABLE   = 1'b1;

	localparam logic [15:0] BYTE_MASK   = 16'h00FF;
	localparam logic [15:0] FLAG_BYTE   = 16'h0080;
	localparam logic [15:0] FLAG_WORD   = 16'h8000;
	localparam logic [6:0]  COUNT_MASK  = 7'h7F;
	localparam logic [7:0]  RED_MASK    = 8'hE0;
	localparam logic [7:0]  GREEN_MASK  = 8'h1C;
	localparam logic [7:0]  BLUE_MASK   = 8'h03;

	typedef struct packed {
		logic [15:0] pixel_color;
		logic [15:0] mono_pattern;
	} unit_out_t;

	function automatic unit_out_t convert_unit(input logic [1:0] fmt, input logic [15:0] unit);
		unit_out_t r;
		logic [7:0] b;
		b = unit[7:0];
		r = '0;
		case (fmt)
			FMT_MONO8:  r.mono_pattern = unit & BYTE_MASK;
			FMT_MONO16: r.mono_pattern = unit;
			FMT_RGB332: r.pixel_color = {b[7:5] & RED_MASK[7:5], 2'b00,
				b[4:2] & GREEN_MASK[4:2], 3'b000, b[1:0] & BLUE_MASK[1:0], 3'b000};
			default:    r.pixel_color = unit;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/rle_image_unit_decoder.sv
// Run-length image unit decoder: headers, repeat and literal runs, RGB332/mono expansion.
// Depends on rlei_pkg.
// The result is registered: an accepted unit's result reaches the result register in the next cycle.
// Throughput: one unit per cycle; input stalls only while a held result is stalled.
// Reset: asynchronous, clears config to mono bytes/raw, phase to header, run length to one.
module rle_image_unit_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] data_unit,
	input  logic        last_unit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_color,
	output logic [15:0] mono_pattern,
	output logic [7:0]  run_length,
	output logic        end_of_image
);

	logic [1:0]       pixel_format_q;
	logic             rle_enable_q;
	rlei_pkg::phase_t phase_q, phase_d;
	logic [6:0]       literal_left_q, literal_left_d;
	logic [7:0]       repeat_length_q, repeat_length_d;
	logic             out_valid_q;
	logic [15:0]      color_q, pattern_q;
	logic [7:0]       run_q;
	logic             eoi_q;

	logic                in_fire;
	logic                wide;
	logic [15:0]         unit;
	logic                flag;
	logic                produce;
	logic [7:0]          run_d;
	rlei_pkg::unit_out_t conv;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign in_fire   = in_valid & ~in_stall;

	assign wide = (pixel_format_q == rlei_pkg::FMT_MONO16) ||
		(pixel_format_q == rlei_pkg::FMT_RGB565);
	assign unit = wide ? data_unit : (data_unit & rlei_pkg::BYTE_MASK);
	assign flag = (pixel_format_q == rlei_pkg::FMT_MONO16) ?
		((unit & rlei_pkg::FLAG_WORD) != 16'd0) : ((unit & rlei_pkg::FLAG_BYTE) != 16'd0);
	assign conv = rlei_pkg::convert_unit(pixel_format_q, unit);

	always_comb begin
		phase_d         = phase_q;
		literal_left_d  = literal_left_q;
		repeat_length_d = repeat_length_q;
		produce         = 1'b0;
		run_d           = 8'd1;
		if (!rle_enable_q) begin
			phase_d         = rlei_pkg::PH_HEADER;
			literal_left_d  = 7'd0;
			repeat_length_d = 8'd1;
			produce         = 1'b1;
		end else begin
			case (phase_q)
				rlei_pkg::PH_REPEAT: begin
					produce         = 1'b1;
					run_d           = repeat_length_q;
					phase_d         = rlei_pkg::PH_HEADER;
					repeat_length_d = 8'd1;
				end
				rlei_pkg::PH_LITERAL: begin
					produce = 1'b1;
					if (literal_left_q == 7'd0)
						phase_d = rlei_pkg::PH_HEADER;
					else
						literal_left_d = literal_left_q - 7'd1;
				end
				default: begin
					if (flag) begin
						repeat_length_d = {1'b0, unit[6:0] & rlei_pkg::COUNT_MASK} + 8'd1;
						phase_d         = rlei_pkg::PH_REPEAT;
					end else begin
						literal_left_d = unit[6:0] & rlei_pkg::COUNT_MASK;
						phase_d        = rlei_pkg::PH_LITERAL;
					end
				end
			endcase
		end
		if (last_unit) begin
			phase_d         = rlei_pkg::PH_HEADER;
			literal_left_d  = 7'd0;
			repeat_length_d = 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q  <= rlei_pkg::FMT_MONO8;
			rle_enable_q    <= 1'b0;
			phase_q         <= rlei_pkg::PH_HEADER;
			literal_left_q  <= 7'd0;
			repeat_length_q <= 8'd1;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rlei_pkg::REG_PIXEL_FORMAT: pixel_format_q <= cfg_data;
					default:                    rle_enable_q   <= cfg_data[0];
				endcase
			end
			if (in_fire) begin
				phase_q         <= phase_d;
				literal_left_q  <= literal_left_d;
				repeat_length_q <= repeat_length_d;
				out_valid_q     <= produce;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire && produce) begin
			color_q   <= conv.pixel_color;
			pattern_q <= conv.mono_pattern;
			run_q     <= run_d;
			eoi_q     <= last_unit;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_color  = color_q;
	assign mono_pattern = pattern_q;
	assign run_length   = run_q;
	assign end_of_image = eoi_q;

endmodule

FILE: bench/rle_image_unit_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench for rle_image_unit_decoder: directed and random image streams in all pixel formats.
// A scoreboard class predicts each decoded pixel and checks it. Random idling on both sides.
// Depends on rlei_pkg and the rle_image_unit_decoder RTL.
module rle_image_unit_decoder_tb;
	import rlei_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [15:0] color;
		logic [15:0] pattern;
		logic [7:0]  run;
		logic        eoi;
	} pixel_t;

	class pixel_scoreboard;
		logic [1:0] fmt;
		logic       rle_on;
		phase_t     phase;
		logic [6:0] lit_left;
		logic [7:0] rep_len;
		pixel_t     expected_pixels[$];
		int         errors;
		int         checked;

		function new();
			fmt = FMT_MONO8;
			rle_on = 1'b0;
			errors = 0;
			checked = 0;
			clear_run();
		endfunction

		function void clear_run();
			phase = PH_HEADER;
			lit_left = '0;
			rep_len = 8'd1;
		endfunction

		function void set_reg(logic idx, logic [1:0] val);
			if (idx == REG_PIXEL_FORMAT)
				fmt = val;
			else
				rle_on = val[0];
		endfunction

		function void push_pixel(logic [15:0] u, logic [7:0] run, logic eoi);
			pixel_t p;
			p.color = '0;
			p.pattern = '0;
			p.run = run;
			p.eoi = eoi;
			case (fmt)
				FMT_MONO8, FMT_MONO16: p.pattern = u;
				FMT_RGB332: p.color = {u[7:5], 2'b00, u[4:2], 3'b000, u[1:0], 3'b000};
				default: p.color = u;
			endcase
			expected_pixels.push_back(p);
		endfunction

		function void note_unit(logic [15:0] raw, logic eoi);
			logic [15:0] u;
			logic        flag;
			u = (fmt == FMT_MONO16 || fmt == FMT_RGB565) ? raw : {8'h00, raw[7:0]};
			if (!rle_on) begin
				clear_run();
				push_pixel(u, 8'd1, eoi);
			end else begin
				case (phase)
					PH_REPEAT: begin
						push_pixel(u, rep_len, eoi);
						phase = PH_HEADER;
						rep_len = 8'd1;
					end
					PH_LITERAL: begin
						push_pixel(u, 8'd1, eoi);
						if (lit_left == 0)
							phase = PH_HEADER;
						else
							lit_left = lit_left - 7'd1;
					end
					default: begin
						flag = (fmt == FMT_MONO16) ? u[15] : u[7];
						if (flag) begin
							rep_len = {1'b0, u[6:0]} + 8'd1;
							phase = PH_REPEAT;
						end else begin
							lit_left = u[6:0];
							phase = PH_LITERAL;
						end
					end
				endcase
			end
			if (eoi)
				clear_run();
		endfunction

		function void check_pixel(logic [15:0] color, logic [15:0] pattern, logic [7:0] run,
				logic eoi);
			pixel_t p;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel color %h pattern %h run %0d eoi %b",
					$time, color, pattern, run, eoi);
				errors++;
			end else begin
				p = expected_pixels.pop_front();
				checked++;
				if (color !== p.color) begin
					$display("%0t: pixel_color expected %h got %h", $time, p.color, color);
					errors++;
				end
				if (pattern !== p.pattern) begin
					$display("%0t: mono_pattern expected %h got %h", $time, p.pattern, pattern);
					errors++;
				end
				if (run !== p.run) begin
					$display("%0t: run_length expected %0d got %0d", $time, p.run, run);
					errors++;
				end
				if (eoi !== p.eoi) begin
					$display("%0t: end_of_image expected %b got %b", $time, p.eoi, eoi);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [1:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] data_unit = '0;
	logic        last_unit = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] pixel_color;
	logic [15:0] mono_pattern;
	logic [7:0]  run_length;
	logic        end_of_image;

	pixel_scoreboard board;
	int gap_pct = 0;
	int stall_pct = 0;
	int cycles = 0;
	int units_accepted = 0;

	rle_image_unit_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_unit(data_unit),
		.last_unit(last_unit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_color(pixel_color),
		.mono_pattern(mono_pattern),
		.run_length(run_length),
		.end_of_image(end_of_image)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_pixel(pixel_color, mono_pattern, run_length, end_of_image);
			if (in_valid && !in_stall) begin
				board.note_unit(data_unit, last_unit);
				units_accepted++;
			end
		end
	end

	// one request per unit; valid held until taken
	task automatic drive_unit(input logic [15:0] d, input logic eoi);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_unit <= d;
		last_unit <= eoi;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_config(input logic [1:0] fmt, input logic rle);
		cfg_valid <= 1'b1;
		cfg_index <= REG_PIXEL_FORMAT;
		cfg_data <= fmt;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(REG_PIXEL_FORMAT, fmt);
		cfg_index <= REG_RLE_ENABLE;
		cfg_data <= {1'b0, rle};
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(REG_RLE_ENABLE, {1'b0, rle});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_image(input logic [1:0] fmt, input logic rle, output int sent);
		logic [15:0] units[$];
		logic [15:0] hdr;
		logic        flag;
		int          target;
		int          count;
		target = $urandom_range(2, 24);
		if (!rle || $urandom_range(9) == 0) begin
			repeat (target) units.push_back(16'($urandom_range(16'hFFFF)));
		end else begin
			while (units.size() < target) begin
				count = ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(7);
				flag = ($urandom_range(1) == 1);
				hdr = 16'($urandom_range(16'hFFFF));
				hdr[6:0] = 7'(count);
				if (fmt == FMT_MONO16)
					hdr[15] = flag;
				else
					hdr[7] = flag;
				units.push_back(hdr);
				if (flag)
					units.push_back(16'($urandom_range(16'hFFFF)));
				else
					repeat (count + 1) units.push_back(16'($urandom_range(16'hFFFF)));
			end
			// broken image: cut anywhere, possibly right after a header
			if ($urandom_range(7) == 0) begin
				count = $urandom_range(1, units.size());
				while (units.size() > count)
					void'(units.pop_back());
			end
		end
		foreach (units[i])
			drive_unit(units[i], i == units.size() - 1);
		sent = units.size();
	endtask

	initial begin
		int seg;
		int sent;
		int seg_units;
		logic [1:0] fmt;
		logic rle;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: raw mono bytes, upper byte ignored
		drive_unit(16'h0000, 1'b0);
		drive_unit(16'hFFFF, 1'b1);
		drain_results();
		write_config(FMT_RGB332, 1'b0);
		drive_unit(16'h00FF, 1'b0);
		drive_unit(16'hFF1C, 1'b1);
		drain_results();
		// longest repeat, short literals, header as last unit
		write_config(FMT_RGB565, 1'b1);
		drive_unit(16'h00FF, 1'b0);
		drive_unit(16'hFFFF, 1'b0);
		drive_unit(16'h0000, 1'b0);
		drive_unit(16'h1234, 1'b0);
		drive_unit(16'h0001, 1'b0);
		drive_unit(16'hABCD, 1'b0);
		drive_unit(16'h8000, 1'b0);
		drive_unit(16'h0085, 1'b1);
		drain_results();
		// mono words: flag in bit 15, bit 7 not a flag
		write_config(FMT_MONO16, 1'b1);
		drive_unit(16'h8000, 1'b0);
		drive_unit(16'hFFFF, 1'b0);
		drive_unit(16'h0080, 1'b0);
		drive_unit(16'h5555, 1'b1);
		drain_results();
		// format change between header and repeat unit
		write_config(FMT_MONO8, 1'b1);
		drive_unit(16'hFF82, 1'b0);
		drain_results();
		write_config(FMT_RGB332, 1'b1);
		drive_unit(16'h00E3, 1'b0);
		drive_unit(16'h007F, 1'b1);
		drain_results();

		for (seg = 0; seg < 16; seg++) begin
			case (seg / 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 50; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 50; end
				default: begin gap_pct = 13; stall_pct = 13; end
			endcase
			fmt = 2'(seg % 4);
			rle = 1'((seg + seg / 4) % 2);
			write_config(fmt, rle);
			seg_units = 0;
			while (seg_units < 18) begin
				send_image(fmt, rle, sent);
				seg_units += sent;
			end
			drain_results();
		end

		$display("accepted %0d units, checked %0d pixels", units_accepted, board.checked);
		$display("all four pixel formats, raw and run-length coded, with and without idling");
		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
